// ----- design/tfmc_pkg.sv -----
// Shared types and constants for the thermal fan mode controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfmc_pkg;

   localparam int DEG_W    = 11;
   localparam int SAMPLE_W = 10;
   localparam int DUTY_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int MSG_W    = 3;
   localparam int MODE_W   = 2;
   localparam int CMD_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 11;
   localparam int PROD_W   = SAMPLE_W + 7;
   localparam int NUM_W    = DEG_W + DUTY_W;
   localparam int DIV_BITS = DUTY_W;
   localparam int BIT_W    = $clog2(DIV_BITS);

   // sample * 5000 / 2560 == sample * 125 / 64
   localparam logic [PROD_W-1:0] DEG_SCALE = PROD_W'(125);
   localparam int DEG_SHIFT = 6;
   localparam logic [NUM_W-1:0] RAMP_SCALE = NUM_W'(254);
   localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
   localparam logic [DUTY_W-1:0] DUTY_OFF  = 8'd0;

   localparam logic [CMD_W-1:0] CMD_STEP   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd2;

   localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EMERGENCY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ABNORMAL  = 2'd2;

   localparam logic [MSG_W-1:0] MSG_SHUTDOWN  = 3'd0;
   localparam logic [MSG_W-1:0] MSG_COOL      = 3'd1;
   localparam logic [MSG_W-1:0] MSG_RAMP      = 3'd2;
   localparam logic [MSG_W-1:0] MSG_WARM      = 3'd3;
   localparam logic [MSG_W-1:0] MSG_EMERGENCY = 3'd4;
   localparam logic [MSG_W-1:0] MSG_ABNORMAL  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_COOL_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WARM_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOT_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_CHECK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHECKS_ABN  = 3'd4;

   localparam logic [DEG_W-1:0]   COOL_RESET  = 11'd20;
   localparam logic [DEG_W-1:0]   WARM_RESET  = 11'd40;
   localparam logic [DEG_W-1:0]   HOT_RESET   = 11'd50;
   localparam logic [COUNT_W-1:0] TICKS_RESET = 8'd25;
   localparam logic [COUNT_W-1:0] CHECKS_RESET = 8'd14;

   typedef struct packed {
      logic             load;
      logic             conv;
      logic             eval;
      logic             div_step;
      logic [BIT_W-1:0] div_bit;
      logic             finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_status_type;

endpackage

// ----- design/tfmc_ctrl.sv -----
// Controller state machine for the thermal fan mode controller.
// Sequences conversion, evaluation, ramp division and response load.
// Depends on tfmc_pkg.
`timescale 1ns / 1ps

module tfmc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tfmc_pkg::dp_status_type status,
   output tfmc_pkg::ctrl_cmd_type  cmd
);
   import tfmc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_EVAL,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [BIT_W-1:0] bit_ff;
   logic             rsp_valid_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.conv     = (state_ff == ST_CONV);
      cmd.eval     = (state_ff == ST_EVAL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.div_bit  = bit_ff;
      cmd.finish   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_CONV;
            end
            ST_CONV: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (status.need_div) begin
                  state_ff <= ST_DIV;
                  bit_ff   <= BIT_W'(DIV_BITS - 1);
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_DIV: begin
               if (bit_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            ST_FINISH: begin
               if (cmd.finish) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONV))
      else $error("accepted request did not start conversion");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && bit_ff == '0) |=> (state_ff == ST_FINISH))
      else $error("divider did not finish after last bit");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("response not presented after finish");

endmodule

// ----- design/tfmc_dp.sv -----
// Datapath for the thermal fan mode controller: settings, mode state,
// degree conversion, ramp divider and response registers. Depends on tfmc_pkg.
`timescale 1ns / 1ps

module tfmc_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  tfmc_pkg::ctrl_cmd_type           cmd,
   output tfmc_pkg::dp_status_type          status,
   input  logic [tfmc_pkg::CMD_W-1:0]       req_cmd,
   input  logic [tfmc_pkg::SAMPLE_W-1:0]    req_adc_sample,
   input  logic                             csr_wr_en,
   input  logic [tfmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tfmc_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output logic [tfmc_pkg::DUTY_W-1:0]      rsp_fan_duty,
   output logic                             rsp_duty_valid,
   output logic [tfmc_pkg::MSG_W-1:0]       rsp_message,
   output logic                             rsp_message_valid,
   output logic                             rsp_shutdown_led,
   output logic                             rsp_restart_request,
   output logic [tfmc_pkg::MODE_W-1:0]      rsp_mode,
   output logic [tfmc_pkg::DEG_W-1:0]       rsp_degrees
);
   import tfmc_pkg::*;

   // settings
   logic [DEG_W-1:0]   cool_ff, warm_ff, hot_ff;
   logic [COUNT_W-1:0] tpc_ff, cta_ff;
   // block state
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [DEG_W-1:0]   last_ff, last_in;
   logic [COUNT_W-1:0] tick_ff, tick_in, check_ff, check_in;
   // request and working registers
   logic [CMD_W-1:0]    cmd_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [DEG_W-1:0]    deg_ff;
   logic [PROD_W-1:0]   deg_prod;
   logic [NUM_W-1:0]    rem_ff, rem_in, trial;
   logic [DEG_W-1:0]    span_ff;
   logic [DUTY_W-1:0]   q_ff;
   logic                use_div_ff;
   logic [DUTY_W-1:0]   res_duty_ff, duty_in;
   logic                res_dv_ff, dv_in, res_mv_ff, mv_in;
   logic                res_led_ff, led_in, res_rst_ff, rst_in;
   logic [MSG_W-1:0]    res_msg_ff, msg_in;
   logic                need_div;
   logic [COUNT_W-1:0]  limit_t, limit_c, tick_next, check_next;
   logic [NUM_W-1:0]    ramp_num;
   logic [DEG_W-1:0]    ramp_span;
   // response registers
   logic [DUTY_W-1:0]   out_duty_ff;
   logic                out_dv_ff, out_mv_ff, out_led_ff, out_rst_ff;
   logic [MSG_W-1:0]    out_msg_ff;
   logic [MODE_W-1:0]   out_mode_ff;
   logic [DEG_W-1:0]    out_deg_ff;

   assign deg_prod   = PROD_W'(sample_ff) * DEG_SCALE;
   assign limit_t    = (tpc_ff == '0) ? COUNT_W'(1) : tpc_ff;
   assign limit_c    = (cta_ff == '0) ? COUNT_W'(1) : cta_ff;
   assign tick_next  = tick_ff + 1'b1;
   assign check_next = check_ff + 1'b1;
   assign ramp_num   = NUM_W'(deg_ff - cool_ff) * RAMP_SCALE;
   assign ramp_span  = warm_ff - cool_ff;
   assign status.need_div = need_div;

   always_comb begin
      mode_in  = mode_ff;
      last_in  = last_ff;
      tick_in  = tick_ff;
      check_in = check_ff;
      duty_in  = DUTY_OFF;
      dv_in    = 1'b0;
      msg_in   = MSG_SHUTDOWN;
      mv_in    = 1'b0;
      led_in   = 1'b0;
      rst_in   = 1'b0;
      need_div = 1'b0;
      case (cmd_ff)
         CMD_STEP: begin
            case (mode_ff)
               MODE_NORMAL: begin
                  last_in = deg_ff;
                  dv_in   = 1'b1;
                  mv_in   = 1'b1;
                  if (deg_ff < cool_ff) begin
                     msg_in = MSG_COOL;
                  end else if (deg_ff <= warm_ff) begin
                     msg_in = MSG_RAMP;
                     if (warm_ff > cool_ff) begin
                        need_div = 1'b1;
                     end else begin
                        duty_in = DUTY_FULL;
                     end
                  end else if (deg_ff <= hot_ff) begin
                     duty_in = DUTY_FULL;
                     msg_in  = MSG_WARM;
                  end else begin
                     duty_in  = DUTY_FULL;
                     msg_in   = MSG_EMERGENCY;
                     mode_in  = MODE_EMERGENCY;
                     tick_in  = '0;
                     check_in = '0;
                  end
               end
               MODE_EMERGENCY: begin
                  duty_in = DUTY_FULL;
                  dv_in   = 1'b1;
               end
               default: begin
                  duty_in  = DUTY_FULL;
                  dv_in    = 1'b1;
                  msg_in   = MSG_ABNORMAL;
                  mv_in    = 1'b1;
                  rst_in   = 1'b1;
                  mode_in  = MODE_NORMAL;
                  tick_in  = '0;
                  check_in = '0;
               end
            endcase
         end
         CMD_TICK: begin
            if (mode_ff == MODE_EMERGENCY) begin
               if (tick_next >= limit_t) begin
                  tick_in  = '0;
                  check_in = check_next;
                  last_in  = deg_ff;
                  if (check_next >= limit_c) begin
                     mode_in  = MODE_ABNORMAL;
                     check_in = '0;
                  end else if (deg_ff < hot_ff) begin
                     mode_in  = MODE_NORMAL;
                     check_in = '0;
                  end
               end else begin
                  tick_in = tick_next;
               end
            end
         end
         CMD_BUTTON: begin
            if (last_ff >= warm_ff && last_ff <= hot_ff) begin
               led_in = 1'b1;
               mv_in  = 1'b1;
               msg_in = MSG_SHUTDOWN;
            end
         end
         default: begin
         end
      endcase
   end

   // restoring division, one quotient bit per step
   always_comb begin
      trial  = NUM_W'(span_ff) << cmd.div_bit;
      rem_in = rem_ff;
      if (rem_ff >= trial) rem_in = rem_ff - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cool_ff  <= COOL_RESET;
         warm_ff  <= WARM_RESET;
         hot_ff   <= HOT_RESET;
         tpc_ff   <= TICKS_RESET;
         cta_ff   <= CHECKS_RESET;
         mode_ff  <= MODE_NORMAL;
         last_ff  <= '0;
         tick_ff  <= '0;
         check_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_COOL_LIMIT:  cool_ff <= csr_wr_data;
               REG_WARM_LIMIT:  warm_ff <= csr_wr_data;
               REG_HOT_LIMIT:   hot_ff  <= csr_wr_data;
               REG_TICKS_CHECK: tpc_ff  <= csr_wr_data[COUNT_W-1:0];
               REG_CHECKS_ABN:  cta_ff  <= csr_wr_data[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.eval) begin
            mode_ff  <= mode_in;
            last_ff  <= last_in;
            tick_ff  <= tick_in;
            check_ff <= check_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_cmd;
         sample_ff <= req_adc_sample;
      end
      if (cmd.conv) begin
         deg_ff <= deg_prod[PROD_W-1:DEG_SHIFT];
      end
      if (cmd.eval) begin
         res_duty_ff <= duty_in;
         res_dv_ff   <= dv_in;
         res_msg_ff  <= msg_in;
         res_mv_ff   <= mv_in;
         res_led_ff  <= led_in;
         res_rst_ff  <= rst_in;
         use_div_ff  <= need_div;
         rem_ff      <= ramp_num;
         span_ff     <= ramp_span;
         q_ff        <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff[cmd.div_bit] <= (rem_ff >= trial);
      end
      if (cmd.finish) begin
         out_duty_ff <= use_div_ff ? (q_ff + 1'b1) : res_duty_ff;
         out_dv_ff   <= res_dv_ff;
         out_msg_ff  <= res_msg_ff;
         out_mv_ff   <= res_mv_ff;
         out_led_ff  <= res_led_ff;
         out_rst_ff  <= res_rst_ff;
         out_mode_ff <= mode_ff;
         out_deg_ff  <= last_ff;
      end
   end

   assign rsp_fan_duty        = out_duty_ff;
   assign rsp_duty_valid      = out_dv_ff;
   assign rsp_message         = out_msg_ff;
   assign rsp_message_valid   = out_mv_ff;
   assign rsp_shutdown_led    = out_led_ff;
   assign rsp_restart_request = out_rst_ff;
   assign rsp_mode            = out_mode_ff;
   assign rsp_degrees         = out_deg_ff;

   a_counters_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_EMERGENCY) |-> (tick_ff == '0 && check_ff == '0))
      else $error("tick or check count left outside emergency");

   a_ramp_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && use_div_ff) |-> (q_ff != DUTY_FULL))
      else $error("ramp quotient out of range");

   a_button_mode: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && cmd_ff == CMD_BUTTON) |=> $stable(mode_ff))
      else $error("button press changed mode");

endmodule

// ----- design/thermal_fan_mode_controller.sv -----
// Thermal fan mode controller, top level.
// Joins tfmc_ctrl and tfmc_dp; depends on tfmc_pkg.
//
// Usage:
//   req channel carries one request (req_cmd, req_adc_sample): control step,
//   timer tick or button press. It is taken at a clock edge with req_valid
//   high and req_stall low. Every request gives exactly one response on the
//   rsp channel, held until an edge with rsp_valid high and rsp_stall low.
//   csr_wr_en writes csr_wr_data into the setting selected by csr_index;
//   the user must see that settings are changed only while no request is
//   in flight; the block itself has no check for this.
// Sequence: a request is converted (ST_CONV) and evaluated (ST_EVAL); a
//   control step in the ramp, with the warm above the cool limit, runs the
//   divider (ST_DIV), one quotient bit per step. Then the response is loaded.
// Throughput: one request at a time; the next is taken the cycle after the
//   response is loaded.
// Reset: synchronous, clears mode and counters, stored degrees and any
//   pending response, and restores the default settings.
// Stall: a finished response waits in the output register while the next
//   request is processed; its load is held off until the register is free.
`timescale 1ns / 1ps

module thermal_fan_mode_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tfmc_pkg::CMD_W-1:0]       req_cmd,
   input  logic [tfmc_pkg::SAMPLE_W-1:0]    req_adc_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tfmc_pkg::DUTY_W-1:0]      rsp_fan_duty,
   output logic                             rsp_duty_valid,
   output logic [tfmc_pkg::MSG_W-1:0]       rsp_message,
   output logic                             rsp_message_valid,
   output logic                             rsp_shutdown_led,
   output logic                             rsp_restart_request,
   output logic [tfmc_pkg::MODE_W-1:0]      rsp_mode,
   output logic [tfmc_pkg::DEG_W-1:0]       rsp_degrees,
   input  logic                             csr_wr_en,
   input  logic [tfmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tfmc_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import tfmc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tfmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tfmc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_cmd             (req_cmd),
      .req_adc_sample      (req_adc_sample),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .rsp_fan_duty        (rsp_fan_duty),
      .rsp_duty_valid      (rsp_duty_valid),
      .rsp_message         (rsp_message),
      .rsp_message_valid   (rsp_message_valid),
      .rsp_shutdown_led    (rsp_shutdown_led),
      .rsp_restart_request (rsp_restart_request),
      .rsp_mode            (rsp_mode),
      .rsp_degrees         (rsp_degrees)
   );

endmodule
